[hw/rtl/tsv_ft_pkg.sv]
package tsv_ft_pkg;

  localparam int MAX_COLUMNS_DEF      = 256;
  localparam int NULL_TOKEN_BYTES_DEF = 8;

  localparam int MAX_RESULTS = 4;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
  localparam int RES_IDX_W   = $clog2(MAX_RESULTS);

  localparam int QUEUE_DEPTH = 8;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NULL_ENABLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NULL_TOKEN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NULL_LENGTH = 2'd3;

  localparam logic [1:0] KIND_DATA      = 2'd0;
  localparam logic [1:0] KIND_FIELD_END = 2'd1;
  localparam logic [1:0] KIND_ERROR     = 2'd2;
  localparam logic [1:0] KIND_END       = 2'd3;

  localparam logic [2:0] ERR_BAD_ESCAPE   = 3'd0;
  localparam logic [2:0] ERR_ESCAPE_END   = 3'd1;
  localparam logic [2:0] ERR_COUNT        = 3'd2;
  localparam logic [2:0] ERR_EMPTY_HEADER = 3'd3;
  localparam logic [2:0] ERR_TOO_MANY     = 3'd4;

  localparam logic [7:0] BOM_0  = 8'hEF;
  localparam logic [7:0] BOM_1  = 8'hBB;
  localparam logic [7:0] BOM_2  = 8'hBF;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_BSL = 8'h5C;
  localparam logic [7:0] CH_T   = 8'h74;
  localparam logic [7:0] CH_N   = 8'h6E;
  localparam logic [7:0] CH_R   = 8'h72;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [7:0] column;
    logic       record_end;
    logic       is_null;
    logic       in_header;
    logic [2:0] error_code;
    logic       last;
  } res_t;

  typedef struct packed {
    logic                 load;
    logic [RES_CNT_W-1:0] count;
  } load_t;

endpackage

[hw/rtl/tsv_ft_ifs.sv]
interface tsv_ft_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_marker;

  modport source(output valid, data_byte, end_marker, input ready);
  modport sink(input valid, data_byte, end_marker, output ready);
endinterface

interface tsv_ft_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic [7:0] column;
  logic       record_end;
  logic       is_null;
  logic       in_header;
  logic [2:0] error_code;
  logic       last;

  modport source(output valid, kind, out_byte, column, record_end, is_null, in_header,
                 error_code, last, input ready);
  modport sink(input valid, kind, out_byte, column, record_end, is_null, in_header,
               error_code, last, output ready);
endinterface

[hw/rtl/tsv_ft_core.sv]
module tsv_ft_core
  import tsv_ft_pkg::*;
#(
  parameter int MAX_COLUMNS      = MAX_COLUMNS_DEF,
  parameter int NULL_TOKEN_BYTES = NULL_TOKEN_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          go,
  input  logic [7:0]                    data_byte,
  input  logic                          end_marker,
  input  logic                          cfg_header_mode,
  input  logic                          cfg_null_enable,
  input  logic [CFG_DATA_W-1:0]         cfg_null_token,
  input  logic [3:0]                    cfg_null_length,
  output res_t [MAX_RESULTS-1:0]        res,
  output logic [RES_CNT_W-1:0]          res_n
);

  localparam int CW  = $clog2(MAX_COLUMNS);
  localparam int EW  = $clog2(MAX_COLUMNS + 1);
  localparam int FLW = $clog2(NULL_TOKEN_BYTES + 2);

  typedef struct packed {
    logic [1:0]     mp;
    logic           hcr;
    logic           hbs;
    logic [CW-1:0]  cc;
    logic [EW-1:0]  ec;
    logic           frd;
    logic           rs;
    logic [FLW-1:0] fl;
    logic           nm;
    logic           eh;
  } st_t;

  typedef struct packed {
    st_t                   s;
    res_t [MAX_RESULTS-1:0] r;
    logic [RES_CNT_W-1:0]  n;
  } ctx_t;

  localparam st_t ST_RESET = '{mp: '0, hcr: 1'b0, hbs: 1'b0, cc: '0, ec: '0, frd: 1'b0,
                               rs: 1'b1, fl: '0, nm: 1'b0, eh: 1'b0};

  st_t  st_r;
  st_t  st_nxt;
  ctx_t c;

  function automatic logic f_in_hdr(st_t s);
    return cfg_header_mode && !s.frd;
  endfunction

  function automatic ctx_t f_emit(ctx_t ci, logic [1:0] kind, logic [7:0] b, logic [7:0] col,
                                  logic rec, logic isn, logic hdr, logic [2:0] code);
    ctx_t co;
    res_t e;
    co = ci;
    e.kind       = kind;
    e.out_byte   = b;
    e.column     = col;
    e.record_end = rec;
    e.is_null    = isn;
    e.in_header  = hdr;
    e.error_code = code;
    e.last       = 1'b0;
    if (co.n < RES_CNT_W'(MAX_RESULTS)) begin
      co.r[co.n[RES_IDX_W-1:0]] = e;
      co.n = co.n + 1'b1;
    end
    return co;
  endfunction

  function automatic ctx_t f_raise(ctx_t ci, logic [2:0] code);
    ctx_t co;
    co = f_emit(ci, KIND_ERROR, 8'd0, 8'(ci.s.cc), 1'b0, 1'b0, f_in_hdr(ci.s), code);
    co.s.eh = 1'b1;
    return co;
  endfunction

  function automatic ctx_t f_data(ctx_t ci, logic [7:0] b);
    ctx_t       co;
    logic [7:0] tb;
    co = f_emit(ci, KIND_DATA, b, 8'(ci.s.cc), 1'b0, 1'b0, f_in_hdr(ci.s), 3'd0);
    if (int'(co.s.fl) < NULL_TOKEN_BYTES) begin
      tb = 8'(cfg_null_token >> {co.s.fl, 3'b000});
      if (tb != b) begin
        co.s.nm = 1'b1;
      end
    end
    if (int'(co.s.fl) < NULL_TOKEN_BYTES + 1) begin
      co.s.fl = co.s.fl + 1'b1;
    end
    co.s.rs = 1'b0;
    return co;
  endfunction

  function automatic ctx_t f_close(ctx_t ci, logic rec);
    ctx_t          co;
    logic          hdr;
    logic          isn;
    logic [EW-1:0] cols;
    hdr = f_in_hdr(ci.s);
    isn = cfg_null_enable && !hdr && (int'(cfg_null_length) <= NULL_TOKEN_BYTES) &&
          (int'(ci.s.fl) == int'(cfg_null_length)) && !ci.s.nm;
    co = f_emit(ci, KIND_FIELD_END, 8'd0, 8'(ci.s.cc), rec, isn, hdr, 3'd0);
    if (hdr && co.s.fl == '0) begin
      return f_raise(co, ERR_EMPTY_HEADER);
    end
    if (rec) begin
      cols = EW'(co.s.cc) + EW'(1);
      if (co.s.frd) begin
        if (cols != co.s.ec) begin
          return f_raise(co, ERR_COUNT);
        end
      end else begin
        co.s.ec  = cols;
        co.s.frd = 1'b1;
      end
      co.s.cc = '0;
      co.s.rs = 1'b1;
    end else begin
      if (co.s.cc == CW'(MAX_COLUMNS - 1)) begin
        return f_raise(co, ERR_TOO_MANY);
      end
      co.s.cc = co.s.cc + 1'b1;
      co.s.rs = 1'b0;
    end
    co.s.fl = '0;
    co.s.nm = 1'b0;
    return co;
  endfunction

  function automatic ctx_t f_replay(ctx_t ci);
    ctx_t co;
    co = ci;
    if (co.s.mp == 2'd1 || co.s.mp == 2'd2) begin
      co = f_data(co, BOM_0);
      if (co.s.mp == 2'd2) begin
        co = f_data(co, BOM_1);
      end
    end
    co.s.mp = 2'd3;
    return co;
  endfunction

  function automatic ctx_t f_handle(ctx_t ci, logic [7:0] b);
    ctx_t co;
    co = ci;
    if (co.s.hbs) begin
      co.s.hbs = 1'b0;
      if (b == CH_BSL) begin
        co = f_data(co, CH_BSL);
      end else if (b == CH_T) begin
        co = f_data(co, CH_TAB);
      end else if (b == CH_N) begin
        co = f_data(co, CH_LF);
      end else if (b == CH_R) begin
        co = f_data(co, CH_CR);
      end else begin
        co = f_raise(co, ERR_BAD_ESCAPE);
      end
      return co;
    end
    if (co.s.hcr) begin
      co.s.hcr = 1'b0;
      if (b == CH_LF) begin
        return f_close(co, 1'b1);
      end
      co = f_data(co, CH_CR);
    end
    if (b == CH_BSL) begin
      co.s.hbs = 1'b1;
      co.s.rs  = 1'b0;
    end else if (b == CH_CR) begin
      co.s.hcr = 1'b1;
      co.s.rs  = 1'b0;
    end else if (b == CH_TAB) begin
      co = f_close(co, 1'b0);
    end else if (b == CH_LF) begin
      co = f_close(co, 1'b1);
    end else begin
      co = f_data(co, b);
    end
    return co;
  endfunction

  always_comb begin
    c   = '0;
    c.s = st_r;
    if (end_marker) begin
      if (!c.s.eh) begin
        c = f_replay(c);
        if (c.s.hbs) begin
          c = f_raise(c, ERR_ESCAPE_END);
        end else begin
          if (c.s.hcr) begin
            c.s.hcr = 1'b0;
            c = f_data(c, CH_CR);
          end
          if (!(c.s.rs && c.s.frd)) begin
            c = f_close(c, 1'b1);
          end
        end
      end
      c   = f_emit(c, KIND_END, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0, 3'd0);
      c.s = ST_RESET;
    end else if (!c.s.eh) begin
      if (c.s.mp == 2'd0 && data_byte == BOM_0) begin
        c.s.mp = 2'd1;
      end else if (c.s.mp == 2'd1 && data_byte == BOM_1) begin
        c.s.mp = 2'd2;
      end else if (c.s.mp == 2'd2 && data_byte == BOM_2) begin
        c.s.mp = 2'd3;
      end else begin
        c = f_replay(c);
        c = f_handle(c, data_byte);
      end
    end
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (c.n != '0 && i == int'(c.n) - 1) begin
        c.r[i].last = 1'b1;
      end
    end
    st_nxt = c.s;
    res    = c.r;
    res_n  = c.n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_RESET;
    end else if (go) begin
      st_r <= st_nxt;
    end
  end

endmodule

[hw/rtl/tsv_ft_outq.sv]
module tsv_ft_outq
  import tsv_ft_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  load_t                  ld,
  input  res_t [MAX_RESULTS-1:0] ld_res,
  output logic                   space_ok,
  output logic                   out_valid,
  input  logic                   out_ready,
  output res_t                   head
);

  res_t              q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] head_r;
  logic [QPTR_W-1:0] tail_r;
  logic [QCNT_W-1:0] cnt_r;
  logic [QCNT_W-1:0] add;
  logic              pop;

  assign out_valid = cnt_r != '0;
  assign head      = q_r[head_r];
  assign pop       = out_valid && out_ready;
  assign add       = ld.load ? QCNT_W'(ld.count) : '0;
  assign space_ok  = cnt_r <= QCNT_W'(QUEUE_DEPTH - MAX_RESULTS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      tail_r <= tail_r + QPTR_W'(add);
      if (pop) begin
        head_r <= head_r + 1'b1;
      end
      cnt_r <= cnt_r + add - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (ld.load) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
        if (i < int'(ld.count)) begin
          q_r[QPTR_W'(tail_r + QPTR_W'(i))] <= ld_res[i];
        end
      end
    end
  end

endmodule

[hw/rtl/tsv_field_tokenizer_top.sv]
// Streaming tokenizer for tab separated text with backslash escapes. Each input transfer
// carries one file byte or an end marker; each output transfer carries one decoded byte,
// field end, error or end-of-data result. A byte is held in the input register until the
// queue has space, is decoded together with the parser state, and its zero to four results
// are written into an eight-entry result queue that drains one result per cycle while the
// output is ready. Ordinary data bytes, which give one result each, stream at one byte per
// cycle while the output is ready. The input register advances whenever the queue holds
// four results or fewer, so a stalled output stops the input only once that space is used.
// An input transfer reaches the output through the input register and the result queue.
module tsv_field_tokenizer_top
  import tsv_ft_pkg::*;
#(
  parameter int MAX_COLUMNS      = MAX_COLUMNS_DEF,
  parameter int NULL_TOKEN_BYTES = NULL_TOKEN_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  tsv_ft_in_if.sink             in_ch,
  tsv_ft_out_if.source          out_ch
);

  logic                   header_mode_r;
  logic                   null_enable_r;
  logic [CFG_DATA_W-1:0]  null_token_r;
  logic [3:0]             null_length_r;

  logic                   in_v_r;
  logic [7:0]             in_byte_r;
  logic                   in_end_r;

  logic                   go;
  logic                   space_ok;
  res_t [MAX_RESULTS-1:0] res;
  logic [RES_CNT_W-1:0]   res_n;
  load_t                  ld;
  res_t                   head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_mode_r <= 1'b0;
      null_enable_r <= 1'b0;
      null_token_r  <= '0;
      null_length_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HEADER_MODE: header_mode_r <= cfg_data[0];
        CFG_NULL_ENABLE: null_enable_r <= cfg_data[0];
        CFG_NULL_TOKEN:  null_token_r  <= cfg_data;
        CFG_NULL_LENGTH: null_length_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign go          = in_v_r && space_ok;
  assign in_ch.ready = !in_v_r || go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_v_r <= 1'b1;
    end else if (go) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_r <= in_ch.data_byte;
      in_end_r  <= in_ch.end_marker;
    end
  end

  tsv_ft_core #(
    .MAX_COLUMNS      (MAX_COLUMNS),
    .NULL_TOKEN_BYTES (NULL_TOKEN_BYTES)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .go              (go),
    .data_byte       (in_byte_r),
    .end_marker      (in_end_r),
    .cfg_header_mode (header_mode_r),
    .cfg_null_enable (null_enable_r),
    .cfg_null_token  (null_token_r),
    .cfg_null_length (null_length_r),
    .res             (res),
    .res_n           (res_n)
  );

  assign ld.load  = go;
  assign ld.count = res_n;

  tsv_ft_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .ld        (ld),
    .ld_res    (res),
    .space_ok  (space_ok),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .head      (head)
  );

  assign out_ch.kind       = head.kind;
  assign out_ch.out_byte   = head.out_byte;
  assign out_ch.column     = head.column;
  assign out_ch.record_end = head.record_end;
  assign out_ch.is_null    = head.is_null;
  assign out_ch.in_header  = head.in_header;
  assign out_ch.error_code = head.error_code;
  assign out_ch.last       = head.last;

endmodule

[hw/rtl/tsv_ft_checker.sv]
module tsv_ft_checker
  import tsv_ft_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] kind,
  input logic [7:0] out_byte,
  input logic [7:0] column,
  input logic       record_end,
  input logic       is_null,
  input logic       in_header,
  input logic       last
);

  // A result that is offered stays offered until it is taken.
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output valid dropped before transfer");

  // A stalled result keeps its kind, byte, column and last flag.
  a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(kind) && $stable(out_byte) && $stable(column) &&
      $stable(last))
    else $error("output payload changed while stalled");

  // No result is offered in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // End of data closes the item and carries no column or header flag.
  a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind == KIND_END |-> last && column == 8'd0 && !in_header)
    else $error("malformed end-of-data result");

  // Record end and null flags appear only on field ends, and the null flag never on header fields.
  a_field_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (record_end || is_null) |-> kind == KIND_FIELD_END && !(is_null && in_header))
    else $error("field flags on a result that is not a field end");

endmodule

bind tsv_field_tokenizer_top tsv_ft_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .kind       (out_ch.kind),
  .out_byte   (out_ch.out_byte),
  .column     (out_ch.column),
  .record_end (out_ch.record_end),
  .is_null    (out_ch.is_null),
  .in_header  (out_ch.in_header),
  .last       (out_ch.last)
);
